>>> sv/simd_permute_reduce_unit_top_defines.svh
// ---------------------------------------------------------------------------
// simd_permute_reduce_unit_top_defines
// Assertion macros shared by the permute and reduction unit.
// ---------------------------------------------------------------------------
`ifndef SIMD_PERMUTE_REDUCE_UNIT_TOP_DEFINES_SVH
`define SIMD_PERMUTE_REDUCE_UNIT_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define SPRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spru assertion failed");

// next-cycle implication
`define SPRU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spru assertion failed");

`endif

>>> sv/spru_pkg.sv
// ---------------------------------------------------------------------------
// spru_pkg
// Types, codes and helpers for the permute and reduction unit.
// ---------------------------------------------------------------------------
package spru_pkg;

    localparam int NUM_VREGS      = 32;
    localparam int VEC_BYTES      = 16;
    localparam int MAX_TABLE_REGS = 4;
    localparam int VRF_DEPTH      = NUM_VREGS * 2;
    localparam int VRF_AW         = $clog2(VRF_DEPTH);

    localparam logic [31:0] EXT_MASK = 32'hBFE08400;
    localparam logic [31:0] EXT_VAL  = 32'h2E000000;
    localparam logic [31:0] TBL_MASK = 32'hBF208C00;
    localparam logic [31:0] TBL_VAL  = 32'h0E000000;
    localparam logic [31:0] PRM_VAL  = 32'h0E000800;
    localparam logic [31:0] ACR_MASK = 32'h9F3E0C00;
    localparam logic [31:0] ACR_VAL  = 32'h0E300800;

    // across-lanes opcodes
    localparam logic [4:0] RO_SADDL = 5'h03;
    localparam logic [4:0] RO_MAX   = 5'h0A;
    localparam logic [4:0] RO_MIN   = 5'h1A;
    localparam logic [4:0] RO_ADD   = 5'h1B;
    localparam logic [4:0] RO_FP0   = 5'h0C;
    localparam logic [4:0] RO_FP1   = 5'h0F;
    localparam logic [4:0] RO_FADDP = 5'h0D;

    // permute sub-ops (low two bits)
    localparam logic [1:0] PO_UZP = 2'd1;
    localparam logic [1:0] PO_TRN = 2'd2;
    localparam logic [1:0] PO_ZIP = 2'd3;
    localparam logic [1:0] PO_RSV = 2'd0;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_UNDEF = 2'd1;
    localparam logic [1:0] ST_UNH   = 2'd2;

    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] CL_NONE = 3'd0;
    localparam logic [2:0] CL_EXT  = 3'd1;
    localparam logic [2:0] CL_TBL  = 3'd2;
    localparam logic [2:0] CL_PRM  = 3'd3;
    localparam logic [2:0] CL_RED  = 3'd4;
    localparam logic [2:0] CL_PADD = 3'd5;

    // operand fetch slots: table rn..rn+3, then rm, then rd, then host
    localparam logic [3:0] SLOT_RM0   = 4'd8;
    localparam logic [3:0] SLOT_RD0   = 4'd10;
    localparam logic [3:0] SLOT_LAST  = 4'd11;
    localparam logic [3:0] SLOT_HOST  = 4'd12;
    localparam int         NUM_SLOTS  = 12;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [3:0] rd_slot;
        logic       cap_en;
        logic [3:0] cap_slot;
        logic       red_en;
        logic       red_first;
        logic [3:0] lane;
        logic       calc;
        logic       wr_en;
        logic       wr_host;
        logic       wr_half;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       go;
        logic [2:0] cls;
        logic [3:0] lanes_m1;
    } stat_t;

    function automatic logic [63:0] size_mask(input logic [1:0] size);
        logic [63:0] m;
        case (size)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] x, input logic [1:0] size);
        logic [63:0] r;
        case (size)
            2'd0:    r = {{56{x[7]}}, x[7:0]};
            2'd1:    r = {{48{x[15]}}, x[15:0]};
            2'd2:    r = {{32{x[31]}}, x[31:0]};
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

>>> sv/spru_vrf.sv
// ---------------------------------------------------------------------------
// spru_vrf
// Vector register file as 64-bit halves; one read, one write port.
// ---------------------------------------------------------------------------
module spru_vrf
    import spru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [VRF_AW-1:0] rd_addr,
    output logic [63:0]       rd_data,
    input  logic              wr_en,
    input  logic [VRF_AW-1:0] wr_addr,
    input  logic [63:0]       wr_data
);

    logic [63:0]          mem [VRF_DEPTH];
    logic [VRF_DEPTH-1:0] vld_reg;
    logic [63:0]          rd_data_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : 64'd0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/spru_datapath.sv
// ---------------------------------------------------------------------------
// spru_datapath
// Request latch, decode, operand buffers, permute/reduce logic, outputs.
// ---------------------------------------------------------------------------
module spru_datapath
    import spru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  operation,
    input  logic [31:0] insn,
    input  logic [31:0] decode,
    input  logic        scalar,
    input  logic        q,
    input  logic        u,
    input  logic [63:0] pc,
    input  logic [4:0]  reg_index,
    input  logic        half_sel,
    input  logic [63:0] write_data,
    output logic [1:0]  status,
    output logic [63:0] next_pc,
    output logic [63:0] read_data
);

    logic [1:0]  op_reg;
    logic [31:0] insn_reg;
    logic [31:0] dec_reg;
    logic        scalar_reg;
    logic        q_reg;
    logic        u_reg;
    logic [63:0] pc_reg;
    logic [4:0]  idx_reg;
    logic        half_reg;
    logic [63:0] wdata_reg;

    logic [63:0]  buf_reg [NUM_SLOTS];
    logic [63:0]  rdata_reg;
    logic [63:0]  acc_reg;
    logic [63:0]  acc_next;
    logic [127:0] res_reg;
    logic [127:0] res_next;
    logic [1:0]   status_reg;
    logic [63:0]  next_pc_reg;
    logic [63:0]  read_data_reg;

    logic [4:0] rd_f, rn_f, rm_f;
    logic [3:0] pos_f;
    logic [1:0] len_f, size_f;
    logic       keep_f;
    logic [2:0] pop_f;
    logic [4:0] rop_f;
    logic [1:0] exec_st;
    logic [2:0] cls;
    logic       wq;

    logic [127:0] av, bv, dv;
    logic [511:0] tab;

    logic              vrf_rd_en;
    logic [VRF_AW-1:0] vrf_rd_addr;
    logic [63:0]       vrf_rd_data;
    logic [VRF_AW-1:0] vrf_wr_addr;
    logic [63:0]       vrf_wr_data;

    assign rd_f   = insn_reg[4:0];
    assign rn_f   = insn_reg[9:5];
    assign rm_f   = insn_reg[20:16];
    assign pos_f  = insn_reg[14:11];
    assign len_f  = insn_reg[14:13];
    assign keep_f = insn_reg[12];
    assign pop_f  = insn_reg[14:12];
    assign rop_f  = insn_reg[16:12];
    assign size_f = insn_reg[23:22];

    assign av  = {buf_reg[1], buf_reg[0]};
    assign bv  = {buf_reg[9], buf_reg[8]};
    assign dv  = {buf_reg[11], buf_reg[10]};
    assign tab = {buf_reg[7], buf_reg[6], buf_reg[5], buf_reg[4],
                  buf_reg[3], buf_reg[2], buf_reg[1], buf_reg[0]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= operation;
            insn_reg   <= insn;
            dec_reg    <= decode;
            scalar_reg <= scalar;
            q_reg      <= q;
            u_reg      <= u;
            pc_reg     <= pc;
            idx_reg    <= reg_index;
            half_reg   <= half_sel;
            wdata_reg  <= write_data;
        end
    end

    // decode, in the priority order of the encoding classes
    always_comb
    begin
        exec_st = ST_UNH;
        cls     = CL_NONE;
        if ((dec_reg & EXT_MASK) == EXT_VAL)
        begin
            exec_st = (!q_reg && pos_f[3]) ? ST_UNDEF : ST_DONE;
            cls     = CL_EXT;
        end
        else if ((dec_reg & TBL_MASK) == TBL_VAL)
        begin
            exec_st = (int'(len_f) + 1 > MAX_TABLE_REGS) ? ST_UNDEF : ST_DONE;
            cls     = CL_TBL;
        end
        else if ((dec_reg & TBL_MASK) == PRM_VAL)
        begin
            exec_st = ((size_f == 2'd3 && !q_reg) || pop_f[1:0] == PO_RSV) ?
                      ST_UNDEF : ST_DONE;
            cls     = CL_PRM;
        end
        else if ((dec_reg & ACR_MASK) == ACR_VAL)
        begin
            if (u_reg && (rop_f == RO_FP0 || rop_f == RO_FP1))
            begin
                exec_st = ST_UNH;
            end
            else if (scalar_reg)
            begin
                if (!u_reg && rop_f == RO_ADD)
                begin
                    exec_st = (size_f != 2'd3) ? ST_UNDEF : ST_DONE;
                    cls     = CL_PADD;
                end
                else if (u_reg && rop_f == RO_FADDP)
                begin
                    exec_st = ST_UNH;
                end
                else
                begin
                    exec_st = ST_UNDEF;
                end
            end
            else if (size_f == 2'd3 || (size_f == 2'd2 && !q_reg))
            begin
                exec_st = ST_UNDEF;
            end
            else if (rop_f inside {RO_SADDL, RO_MAX, RO_MIN, RO_ADD})
            begin
                exec_st = ST_DONE;
                cls     = CL_RED;
            end
            else
            begin
                exec_st = ST_UNDEF;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.go       = (op_reg == OP_EXEC) && (exec_st == ST_DONE);
    assign stat.cls      = cls;
    assign stat.lanes_m1 = 4'((({q_reg, ~q_reg, 3'b000}) >> size_f) - 5'd1);

    // operand fetch addressing
    always_comb
    begin
        logic [4:0] r;
        r = rn_f + {3'd0, cmd.rd_slot[2:1]};
        if (cmd.rd_slot == SLOT_HOST)
        begin
            vrf_rd_addr = {idx_reg, half_reg};
        end
        else if (cmd.rd_slot >= SLOT_RD0)
        begin
            vrf_rd_addr = {rd_f, cmd.rd_slot[0]};
        end
        else if (cmd.rd_slot >= SLOT_RM0)
        begin
            vrf_rd_addr = {rm_f, cmd.rd_slot[0]};
        end
        else
        begin
            vrf_rd_addr = {r, cmd.rd_slot[0]};
        end
    end

    assign vrf_rd_en = cmd.rd_en;

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            if (cmd.cap_slot == SLOT_HOST)
            begin
                rdata_reg <= vrf_rd_data;
            end
            else
            begin
                buf_reg[cmd.cap_slot] <= vrf_rd_data;
            end
        end
    end

    // one lane of an across-lanes reduction per step
    always_comb
    begin
        logic [3:0]  boff;
        logic [63:0] e, sx, ex;
        logic [1:0]  ms;
        logic        gt, lt;
        boff = cmd.lane << size_f;
        e    = 64'(av >> {boff, 3'b000}) & size_mask(size_f);
        sx   = sext(e, size_f);
        ex   = u_reg ? e : sx;
        ms   = (rop_f == RO_SADDL) ? size_f + 2'd1 : size_f;
        gt   = u_reg ? (e > acc_reg) : ($signed(sx) > $signed(sext(acc_reg, size_f)));
        lt   = u_reg ? (e < acc_reg) : ($signed(sx) < $signed(sext(acc_reg, size_f)));
        if (cmd.red_first)
        begin
            acc_next = (rop_f == RO_SADDL) ? (ex & size_mask(ms)) : e;
        end
        else
        begin
            case (rop_f)
                RO_SADDL: acc_next = (acc_reg + ex) & size_mask(ms);
                RO_ADD:   acc_next = (acc_reg + e) & size_mask(size_f);
                RO_MAX:   acc_next = gt ? e : acc_reg;
                RO_MIN:   acc_next = lt ? e : acc_reg;
                default:  acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.red_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // permute and table results
    always_comb
    begin
        logic [255:0] cat;
        logic [4:0]   sidx;
        logic [7:0]   sel;
        logic [2:0]   lenp1;
        logic [7:0]   limit;
        logic [4:0]   lanes;
        logic [3:0]   hlf, li, kk, ln, sb;
        logic         useb;
        res_next = '0;
        sidx  = '0;
        sel   = '0;
        li    = '0;
        kk    = '0;
        ln    = '0;
        sb    = '0;
        useb  = 1'b0;
        cat   = q_reg ? {bv, av} : {128'd0, bv[63:0], av[63:0]};
        lenp1 = {1'b0, len_f} + 3'd1;
        limit = {1'b0, lenp1, 4'b0000};
        lanes = {q_reg, ~q_reg, 3'b000} >> size_f;
        hlf   = lanes[4:1];
        case (cls)
            CL_EXT:
            begin
                for (int i = 0; i < VEC_BYTES; i++)
                begin
                    sidx = {1'b0, pos_f} + 5'(i);
                    res_next[i*8 +: 8] = cat[{sidx, 3'b000} +: 8];
                end
            end
            CL_TBL:
            begin
                for (int i = 0; i < VEC_BYTES; i++)
                begin
                    sel = bv[i*8 +: 8];
                    if (sel < limit)
                    begin
                        res_next[i*8 +: 8] = tab[{sel[5:0], 3'b000} +: 8];
                    end
                    else if (!keep_f)
                    begin
                        res_next[i*8 +: 8] = 8'd0;
                    end
                    else
                    begin
                        res_next[i*8 +: 8] = dv[i*8 +: 8];
                    end
                end
            end
            CL_PRM:
            begin
                for (int j = 0; j < VEC_BYTES; j++)
                begin
                    li = 4'(j) >> size_f;
                    kk = 4'(j) & ~(4'hF << size_f);
                    case (pop_f[1:0])
                        PO_UZP:
                        begin
                            useb = (li >= hlf);
                            ln   = ((useb ? li - hlf : li) << 1) + {3'd0, pop_f[2]};
                        end
                        PO_TRN:
                        begin
                            useb = li[0];
                            ln   = {li[3:1], pop_f[2]};
                        end
                        default:
                        begin
                            useb = li[0];
                            ln   = (pop_f[2] ? hlf : 4'd0) + (li >> 1);
                        end
                    endcase
                    sb = (ln << size_f) | kk;
                    res_next[j*8 +: 8] = useb ? bv[{sb, 3'b000} +: 8] : av[{sb, 3'b000} +: 8];
                end
            end
            CL_RED:  res_next = {64'd0, acc_reg};
            CL_PADD: res_next = {64'd0, av[63:0] + av[127:64]};
            default: res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            res_reg <= res_next;
        end
    end

    // narrow forms and all scalar results clear the upper half
    assign wq = (cls == CL_EXT || cls == CL_TBL || cls == CL_PRM) ? q_reg : 1'b0;

    always_comb
    begin
        if (cmd.wr_host)
        begin
            vrf_wr_addr = {idx_reg, half_reg};
            vrf_wr_data = wdata_reg;
        end
        else
        begin
            vrf_wr_addr = {rd_f, cmd.wr_half};
            vrf_wr_data = cmd.wr_half ? (wq ? res_reg[127:64] : 64'd0) : res_reg[63:0];
        end
    end

    spru_vrf u_vrf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (vrf_rd_en),
        .rd_addr (vrf_rd_addr),
        .rd_data (vrf_rd_data),
        .wr_en   (cmd.wr_en),
        .wr_addr (vrf_wr_addr),
        .wr_data (vrf_wr_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (op_reg)
                OP_EXEC:  status_reg <= exec_st;
                OP_WRITE: status_reg <= ST_DONE;
                OP_READ:  status_reg <= ST_DONE;
                default:  status_reg <= ST_UNH;
            endcase
            next_pc_reg   <= stat.go ? pc_reg + 64'd4 : pc_reg;
            read_data_reg <= (op_reg == OP_READ) ? rdata_reg : 64'd0;
        end
    end

    assign status    = status_reg;
    assign next_pc   = next_pc_reg;
    assign read_data = read_data_reg;

endmodule

>>> sv/spru_ctrl.sv
// ---------------------------------------------------------------------------
// spru_ctrl
// Sequencer: fetch, reduce, compute, write back, deliver.
// ---------------------------------------------------------------------------
module spru_ctrl
    import spru_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_RWAIT = 4'd3;
    localparam logic [3:0] S_RED   = 4'd4;
    localparam logic [3:0] S_CALC  = 4'd5;
    localparam logic [3:0] S_WR0   = 4'd6;
    localparam logic [3:0] S_WR1   = 4'd7;
    localparam logic [3:0] S_HWR   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       cap_reg, cap_next;
    logic [3:0] cap_slot_reg, cap_slot_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= 1'b0;
            cap_slot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            cap_slot_reg  <= cap_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.cap_en     = cap_reg;
        cmd.cap_slot   = cap_slot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cnt_next = '0;
                if (stat.op == OP_WRITE)
                begin
                    state_next = S_HWR;
                end
                else if (stat.op == OP_READ)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_slot = SLOT_HOST;
                    state_next  = S_RWAIT;
                end
                else if (stat.go)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_slot = cnt_reg;
                if (cnt_reg == SLOT_LAST)
                begin
                    state_next = S_RWAIT;
                end
                cnt_next = (cnt_reg == SLOT_LAST) ? 4'd0 : cnt_reg + 4'd1;
            end
            S_RWAIT:
            begin
                if (stat.op == OP_READ)
                begin
                    state_next = S_DONE;
                end
                else if (stat.cls == CL_RED)
                begin
                    state_next = S_RED;
                end
                else
                begin
                    state_next = S_CALC;
                end
            end
            S_RED:
            begin
                cmd.red_en    = 1'b1;
                cmd.red_first = (cnt_reg == 4'd0);
                cmd.lane      = cnt_reg;
                if (cnt_reg == stat.lanes_m1)
                begin
                    state_next = S_CALC;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_WR0;
            end
            S_WR0:
            begin
                cmd.wr_en  = 1'b1;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_half = 1'b1;
                state_next  = S_DONE;
            end
            S_HWR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_host = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cap_next      = cmd.rd_en;
        cap_slot_next = cmd.rd_slot;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> sv/simd_permute_reduce_unit_top.sv
// ---------------------------------------------------------------------------
// simd_permute_reduce_unit_top
// AArch64 Advanced SIMD permute and integer reduction unit with its own
// 32 x 128-bit vector register file.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request beat: execute an
//   instruction, write a register half or read a register half. Output
//   channel (out_valid/out_ready) returns one beat per request: status,
//   next pc and read data.
//   One request is in flight at a time. An executed instruction fetches a
//   fixed twelve 64-bit halves (four table registers, Rm, Rd) through the
//   register file's one read port, reductions then step through their
//   lanes one per step (lanes = 4..16), and the 128-bit result is written
//   back in two 64-bit halves. Register writes, register reads and
//   rejected or unhandled instructions skip the operand fetch.
//   The result sits in an output register, so a new request is taken while
//   the previous result waits; a stalled receiver only holds the block at
//   the point of delivering the next result.
//   Reset: the register file reads as zero (per-entry valid bits cleared),
//   no result is pending and the block is ready at once.
// ---------------------------------------------------------------------------
`include "simd_permute_reduce_unit_top_defines.svh"

module simd_permute_reduce_unit_top
    import spru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] insn,
    input  logic [31:0] decode,
    input  logic        scalar,
    input  logic        q,
    input  logic        u,
    input  logic [63:0] pc,
    input  logic [4:0]  reg_index,
    input  logic        half_sel,
    input  logic [63:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] next_pc,
    output logic [63:0] read_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: owns the handshakes and every counter
    spru_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: decode, register file, operand buffers, result registers
    spru_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .operation  (operation),
        .insn       (insn),
        .decode     (decode),
        .scalar     (scalar),
        .q          (q),
        .u          (u),
        .pc         (pc),
        .reg_index  (reg_index),
        .half_sel   (half_sel),
        .write_data (write_data),
        .status     (status),
        .next_pc    (next_pc),
        .read_data  (read_data)
    );

    // a taken request keeps the block busy for at least the next cycle
    `SPRU_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // read data only ever comes back with a successful status
    `SPRU_ASSERT_IMP(a_rdata_done, out_valid && (read_data != 64'd0), status == ST_DONE)
    // status code is one of the three defined values
    `SPRU_ASSERT_IMP(a_status_legal, out_valid, (status == ST_DONE) || (status == ST_UNDEF) || (status == ST_UNH))

endmodule
